// File: design/bmhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types, codes and default sizes for the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int DEF_KEY_BITS = 32;
    localparam int DEF_TAG_BITS = 9;

    localparam int ERR_BITS = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [ERR_BITS-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_BITS-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_BITS-1:0] ERR_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_POP_LOAD,
        ST_POP_RD,
        ST_POP_CMP,
        ST_DONE
    } bmhq_state_t;

endpackage

// File: design/bmhq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ram
// Heap entry storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 41
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: design/bmhq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_seq
// Sift sequencer: walks the heap one level per pass, moving the hole
// instead of swapping entries.
// ----------------------------------------------------------------------------
module bmhq_seq #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 9,
    parameter int IDX_W    = 8,
    parameter int CNT_W    = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_opcode,
    input  logic [KEY_BITS-1:0]          in_key,
    input  logic [TAG_BITS-1:0]          in_tag,
    output logic                         in_ready,
    output logic                         res_valid,
    input  logic                         res_take,
    output logic [KEY_BITS-1:0]          res_key,
    output logic [TAG_BITS-1:0]          res_tag,
    output logic [CNT_W-1:0]             res_count,
    output logic [bmhq_pkg::ERR_BITS-1:0] res_err,
    output logic                         wr_en,
    output logic [IDX_W-1:0]             wr_addr,
    output logic [KEY_BITS+TAG_BITS-1:0] wr_data,
    output logic [IDX_W-1:0]             rd_addr_a,
    output logic [IDX_W-1:0]             rd_addr_b,
    input  logic [KEY_BITS+TAG_BITS-1:0] rd_data_a,
    input  logic [KEY_BITS+TAG_BITS-1:0] rd_data_b
);

    import bmhq_pkg::*;

    localparam int CH_W = IDX_W + 2;

    bmhq_state_t         state_reg,   state_next;
    logic [IDX_W-1:0]    pos_reg,     pos_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    logic [TAG_BITS-1:0] cur_tag_reg, cur_tag_next;
    logic [KEY_BITS-1:0] res_key_reg, res_key_next;
    logic [TAG_BITS-1:0] res_tag_reg, res_tag_next;
    logic [ERR_BITS-1:0] res_err_reg, res_err_next;

    logic [IDX_W-1:0]    parent_idx;
    logic [CH_W-1:0]     left_idx;
    logic [CH_W-1:0]     right_idx;
    logic [CNT_W-1:0]    last_idx;
    logic [KEY_BITS-1:0] key_a;
    logic [KEY_BITS-1:0] key_b;
    logic                left_ok;
    logic                right_ok;
    logic                take_left;
    logic                take_right;

    assign parent_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + CH_W'(1);
    assign last_idx   = count_reg - CNT_W'(1);
    assign key_a      = rd_data_a[KEY_BITS-1:0];
    assign key_b      = rd_data_b[KEY_BITS-1:0];

    // Smaller child with strict compares: left first, right must beat the winner
    assign left_ok    = left_idx < CH_W'(count_reg);
    assign right_ok   = right_idx < CH_W'(count_reg);
    assign take_left  = left_ok && (key_a < cur_key_reg);
    assign take_right = right_ok && (take_left ? (key_b < key_a) : (key_b < cur_key_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        cur_key_reg <= cur_key_next;
        cur_tag_reg <= cur_tag_next;
        res_key_reg <= res_key_next;
        res_tag_reg <= res_tag_next;
        res_err_reg <= res_err_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        cur_key_next = cur_key_reg;
        cur_tag_next = cur_tag_reg;
        res_key_next = res_key_reg;
        res_tag_next = res_tag_reg;
        res_err_next = res_err_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = {cur_tag_reg, cur_key_reg};
        rd_addr_a    = '0;
        rd_addr_b    = '0;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_key_next = '0;
                    res_tag_next = '0;
                    res_err_next = ERR_OK;
                    if (in_opcode == OP_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            res_err_next = ERR_EMPTY;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            // Fetch root and last entry together
                            rd_addr_a  = '0;
                            rd_addr_b  = last_idx[IDX_W-1:0];
                            state_next = ST_POP_LOAD;
                        end
                    end
                    else
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_err_next = ERR_FULL;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            cur_key_next = in_key;
                            cur_tag_next = in_tag;
                            pos_next     = count_reg[IDX_W-1:0];
                            count_next   = count_reg + CNT_W'(1);
                            state_next   = ST_PUSH_RD;
                        end
                    end
                end
            end

            ST_PUSH_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_addr_a  = parent_idx;
                    state_next = ST_PUSH_CMP;
                end
            end

            ST_PUSH_CMP:
            begin
                wr_en = 1'b1;
                if (key_a > cur_key_reg)
                begin
                    // Pull the parent down into the hole and climb
                    wr_data    = rd_data_a;
                    pos_next   = parent_idx;
                    state_next = ST_PUSH_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_POP_LOAD:
            begin
                res_key_next = key_a;
                res_tag_next = rd_data_a[KEY_BITS +: TAG_BITS];
                cur_key_next = key_b;
                cur_tag_next = rd_data_b[KEY_BITS +: TAG_BITS];
                count_next   = last_idx;
                pos_next     = '0;
                state_next   = (last_idx == '0) ? ST_DONE : ST_POP_RD;
            end

            ST_POP_RD:
            begin
                rd_addr_a  = left_idx[IDX_W-1:0];
                rd_addr_b  = right_idx[IDX_W-1:0];
                state_next = ST_POP_CMP;
            end

            ST_POP_CMP:
            begin
                wr_en = 1'b1;
                if (take_right)
                begin
                    wr_data    = rd_data_b;
                    pos_next   = right_idx[IDX_W-1:0];
                    state_next = ST_POP_RD;
                end
                else if (take_left)
                begin
                    wr_data    = rd_data_a;
                    pos_next   = left_idx[IDX_W-1:0];
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_key   = res_key_reg;
    assign res_tag   = res_tag_reg;
    assign res_count = count_reg;
    assign res_err   = res_err_reg;

endmodule

// File: design/binary_min_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue of (key, tag) entries with push and pop.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; s_tready is high only while the
// sequencer is idle. Each heap level takes a registered read of the entry
// memory and then a compare and write back. A pop on an empty heap or a
// push on a full heap goes straight to the done state and leaves the heap
// untouched. Results land in an output register, so the next transfer is
// accepted while a result waits. Ties keep the parent; between equal
// children the left one is taken.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
    parameter int CAPACITY  = bmhq_pkg::DEF_CAPACITY,
    parameter int KEY_BITS  = bmhq_pkg::DEF_KEY_BITS,
    parameter int TAG_BITS  = bmhq_pkg::DEF_TAG_BITS,
    parameter int CNT_W     = $clog2(CAPACITY + 1),
    parameter int S_TDATA_W = ((KEY_BITS + TAG_BITS + 7) / 8) * 8,
    parameter int M_TDATA_W = ((KEY_BITS + TAG_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // push_key, push_tag, zero pad
    input  logic [0:0]           s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // pop_key, pop_tag, entry_count, zero pad
    output logic [bmhq_pkg::ERR_BITS-1:0] m_tuser // error_code
);

    import bmhq_pkg::*;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W = KEY_BITS + TAG_BITS;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [KEY_BITS-1:0] out_key_reg;
    logic [TAG_BITS-1:0] out_tag_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic [ERR_BITS-1:0] out_err_reg;

    logic                res_valid;
    logic                res_take;
    logic [KEY_BITS-1:0] res_key;
    logic [TAG_BITS-1:0] res_tag;
    logic [CNT_W-1:0]    res_count;
    logic [ERR_BITS-1:0] res_err;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [IDX_W-1:0]    rd_addr_a;
    logic [IDX_W-1:0]    rd_addr_b;
    logic [DATA_W-1:0]   rd_data_a;
    logic [DATA_W-1:0]   rd_data_b;

    bmhq_seq #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser[0]),
        .in_key    (s_tdata[KEY_BITS-1:0]),
        .in_tag    (s_tdata[KEY_BITS +: TAG_BITS]),
        .in_ready  (s_tready),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_key   (res_key),
        .res_tag   (res_tag),
        .res_count (res_count),
        .res_err   (res_err),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    bmhq_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Load the output register when it is empty or being drained this cycle
    assign res_take = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_take)
        begin
            m_tvalid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_key_reg   <= res_key;
            out_tag_reg   <= res_tag;
            out_count_reg <= res_count;
            out_err_reg   <= res_err;
        end
    end

    always_comb
    begin
        m_tdata = '0;
        m_tdata[KEY_BITS-1:0]                 = out_key_reg;
        m_tdata[KEY_BITS +: TAG_BITS]         = out_tag_reg;
        m_tdata[KEY_BITS + TAG_BITS +: CNT_W] = out_count_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_err_reg;

endmodule

// File: design/bmhq_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_check
// Port-level checks for the binary min-heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_check #(
    parameter int CAPACITY  = 256,
    parameter int KEY_BITS  = 32,
    parameter int TAG_BITS  = 9,
    parameter int CNT_W     = 9,
    parameter int M_TDATA_W = 56
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [bmhq_pkg::ERR_BITS-1:0] m_tuser
);

    import bmhq_pkg::*;

    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic [CNT_W-1:0]    out_count;

    assign out_key   = m_tdata[KEY_BITS-1:0];
    assign out_tag   = m_tdata[KEY_BITS +: TAG_BITS];
    assign out_count = m_tdata[KEY_BITS + TAG_BITS +: CNT_W];

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One operation at a time: no back-to-back input transfers
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an operation is in flight");

    // Pop on empty heap reports an empty heap and zero payload
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ERR_EMPTY) |->
            (out_key == '0) && (out_tag == '0) && (out_count == '0))
        else $error("empty pop result is not clean");

    // Push on full heap leaves the count at capacity and zero payload
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ERR_FULL) |->
            (out_count == CNT_W'(CAPACITY)) && (out_key == '0) && (out_tag == '0))
        else $error("full push result is not clean");

endmodule

bind binary_min_heap_queue bmhq_check #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .TAG_BITS  (TAG_BITS),
    .CNT_W     (CNT_W),
    .M_TDATA_W (M_TDATA_W)
) u_bmhq_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_min_heap_queue. A clocked driver streams
// push/pop operations from a pending queue, while a monitor predicts each
// result with a local heap and compares every output transfer field by field.
// The run steps through several idle/stall mixes and includes one long
// back-pressure stretch on the result side.
// ----------------------------------------------------------------------------
module testbench;
    import bmhq_pkg::*;

    localparam int CAPACITY  = DEF_CAPACITY;
    localparam int KEY_BITS  = DEF_KEY_BITS;
    localparam int TAG_BITS  = DEF_TAG_BITS;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int S_TDATA_W = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((KEY_BITS + TAG_BITS + CNT_W + 7) / 8) * 8;

    localparam int PHASE_LEN     = 64;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct {
        logic                op;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } heap_op_t;

    typedef struct {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic [CNT_W-1:0]    count;
        logic [ERR_BITS-1:0] err;
    } heap_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // push_key, push_tag, zero pad
    logic [0:0]           s_tuser = '0;    // opcode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // pop_key, pop_tag, entry_count, zero pad
    logic [ERR_BITS-1:0]  m_tuser;         // error_code

    heap_op_t     op_pending[$];
    heap_result_t results_due[$];

    // local copy of the heap used for prediction
    logic [KEY_BITS-1:0] shadow_keys[CAPACITY];
    logic [TAG_BITS-1:0] shadow_tags[CAPACITY];
    int unsigned         shadow_size = 0;

    int unsigned ops_taken = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_count = 0;
    int unsigned gen_count = 0;

    binary_min_heap_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // heap predictor
    // ------------------------------------------------------------------
    function automatic void exchange_slots(input int unsigned a, input int unsigned b);
        logic [KEY_BITS-1:0] k;
        logic [TAG_BITS-1:0] t;
        k = shadow_keys[a];
        t = shadow_tags[a];
        shadow_keys[a] = shadow_keys[b];
        shadow_tags[a] = shadow_tags[b];
        shadow_keys[b] = k;
        shadow_tags[b] = t;
    endfunction

    function automatic heap_result_t heap_apply(input heap_op_t item);
        heap_result_t r;
        int unsigned  pos;
        int unsigned  parent;
        int unsigned  left;
        int unsigned  right;
        int unsigned  best;
        r.key = '0;
        r.tag = '0;
        r.err = ERR_OK;
        if (item.op == OP_PUSH)
        begin
            if (shadow_size >= CAPACITY)
            begin
                r.err = ERR_FULL;
            end
            else
            begin
                pos = shadow_size;
                shadow_keys[pos] = item.key;
                shadow_tags[pos] = item.tag;
                shadow_size++;
                // climb while the parent is strictly greater
                while (pos != 0)
                begin
                    parent = (pos - 1) / 2;
                    if (shadow_keys[parent] > shadow_keys[pos])
                    begin
                        exchange_slots(parent, pos);
                        pos = parent;
                    end
                    else
                    begin
                        break;
                    end
                end
            end
        end
        else
        begin
            if (shadow_size == 0)
            begin
                r.err = ERR_EMPTY;
            end
            else
            begin
                r.key = shadow_keys[0];
                r.tag = shadow_tags[0];
                shadow_size--;
                shadow_keys[0] = shadow_keys[shadow_size];
                shadow_tags[0] = shadow_tags[shadow_size];
                pos = 0;
                // descend toward the smaller child; ties keep the parent,
                // equal children pick the left one
                forever
                begin
                    left  = 2 * pos + 1;
                    right = 2 * pos + 2;
                    best  = pos;
                    if (left < shadow_size && shadow_keys[left] < shadow_keys[best])
                        best = left;
                    if (right < shadow_size && shadow_keys[right] < shadow_keys[best])
                        best = right;
                    if (best == pos)
                        break;
                    exchange_slots(pos, best);
                    pos = best;
                end
            end
        end
        r.count = CNT_W'(shadow_size);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    function automatic void add_op(input logic op, input logic [KEY_BITS-1:0] key,
                                   input logic [TAG_BITS-1:0] tag);
        heap_op_t item;
        item.op  = op;
        item.key = key;
        item.tag = tag;
        op_pending.push_back(item);
        if (op == OP_PUSH && gen_count < CAPACITY)
            gen_count++;
        else if (op == OP_POP && gen_count > 0)
            gen_count--;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        logic [KEY_BITS-1:0] k;
        case ($urandom_range(0, 3))
            0, 1:    k = $urandom;
            2:       k = KEY_BITS'($urandom_range(0, 7));   // dense range forces ties
            default: k = {KEY_BITS{1'b1}} - KEY_BITS'($urandom_range(0, 15));
        endcase
        return k;
    endfunction

    function automatic void add_random_op(input int unsigned push_pct);
        logic op;
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        add_op(op, pick_key(), TAG_BITS'($urandom_range(0, (1 << TAG_BITS) - 1)));
    endfunction

    initial
    begin
        // directed: empty pop, key/tag extremes, ties with parent and siblings
        add_op(OP_POP,  32'hFFFF_FFFF, 9'h1FF);
        add_op(OP_PUSH, 32'hFFFF_FFFF, 9'h1FF);
        add_op(OP_PUSH, 32'h0000_0000, 9'h000);
        add_op(OP_PUSH, 32'd5, 9'd10);
        add_op(OP_PUSH, 32'd5, 9'd11);
        add_op(OP_PUSH, 32'd5, 9'd12);
        add_op(OP_PUSH, 32'd5, 9'd13);
        add_op(OP_PUSH, 32'd0, 9'd1);
        add_op(OP_PUSH, 32'h8000_0000, 9'h100);
        add_op(OP_PUSH, 32'h7FFF_FFFF, 9'h0FF);
        repeat (9)
            add_op(OP_POP, 32'hA5A5_A5A5, 9'h155);
        add_op(OP_POP,  32'h5A5A_5A5A, 9'h0AA);
        add_op(OP_PUSH, 32'h0000_0001, 9'h001);
        add_op(OP_POP,  32'h0000_0000, 9'h000);

        // mostly pushes until full, then push past full
        while (gen_count < CAPACITY)
            add_random_op(97);
        repeat (3)
            add_random_op(100);
        // mostly pops until empty, then pop past empty
        while (gen_count > 0)
            add_random_op(3);
        repeat (3)
            add_random_op(0);
        repeat (40)
            add_random_op(60);

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (op_pending.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("** binary_min_heap_queue: PASSED **");
        else
            $display("** binary_min_heap_queue: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // idle/stall mix: 0 none, 1 sender idle, 2 receiver stall, 3 both
    // ------------------------------------------------------------------
    function automatic logic roll(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int unsigned sender_idle_pct();
        case ((ops_taken / PHASE_LEN) % 4)
            1:       return 87;
            3:       return 33;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct();
        case ((ops_taken / PHASE_LEN) % 4)
            2:       return 87;
            3:       return 33;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        heap_op_t item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (op_pending.size() != 0 && !roll(sender_idle_pct()))
            begin
                item = op_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'({item.tag, item.key});
                s_tuser  <= item.op;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long back-pressure stretch on the result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && ops_taken >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && !roll(receiver_stall_pct());
    end

    // ------------------------------------------------------------------
    // monitor: predict on input transfer, check on output transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        heap_op_t     item;
        heap_result_t want;
        heap_result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                item.op  = s_tuser[0];
                item.key = s_tdata[KEY_BITS-1:0];
                item.tag = s_tdata[KEY_BITS +: TAG_BITS];
                results_due.push_back(heap_apply(item));
                ops_taken <= ops_taken + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got.key   = m_tdata[KEY_BITS-1:0];
                got.tag   = m_tdata[KEY_BITS +: TAG_BITS];
                got.count = m_tdata[KEY_BITS + TAG_BITS +: CNT_W];
                got.err   = m_tuser;
                if (results_due.size() == 0)
                begin
                    $error("result transfer with no operation outstanding");
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.key !== want.key)
                    begin
                        $error("pop_key: expected %0h, got %0h", want.key, got.key);
                        fail_count++;
                    end
                    if (got.tag !== want.tag)
                    begin
                        $error("pop_tag: expected %0h, got %0h", want.tag, got.tag);
                        fail_count++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count, got.count);
                        fail_count++;
                    end
                    if (got.err !== want.err)
                    begin
                        $error("error_code: expected %0d, got %0d", want.err, got.err);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** binary_min_heap_queue: FAILED **");
                $finish;
            end
        end
    end

endmodule

// File: sim.f
design/bmhq_pkg.sv
design/bmhq_ram.sv
design/bmhq_seq.sv
design/binary_min_heap_queue.sv
design/bmhq_check.sv
tb/sv/testbench.sv
